>>> rtl/kst_pkg.sv
package kst_pkg;

  localparam int unsigned KeyW  = 6;
  localparam int unsigned TimeW = 16;
  localparam int unsigned CharW = 8;
  localparam int unsigned ElapW = 10;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_DELAY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 2'd1;

  localparam logic [CfgW-1:0] DELAY_RESET    = 16'd500;
  localparam logic [CfgW-1:0] INTERVAL_RESET = 16'd100;

  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

  typedef enum logic [2:0] {
    ST_UP       = 3'd0,
    ST_DOWN     = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_REPEAT   = 3'd4
  } key_st_e;

  typedef struct packed {
    key_st_e            st;
    logic [TimeW-1:0]   held;
    logic [CharW-1:0]   chr;
  } entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [KeyW-1:0]    rd_addr;
    logic               wr_en;
    logic [KeyW-1:0]    wr_addr;
    entry_t             wr_data;
  } mem_req_t;

  typedef struct packed {
    logic               opcode;
    logic [ElapW-1:0]   elapsed_ms;
    logic [KeyW-1:0]    key_index;
    logic               is_press;
    logic [CharW-1:0]   key_char;
  } in_req_t;

  typedef struct packed {
    logic [KeyW-1:0]    repeat_key;
    logic [CharW-1:0]   repeat_char;
    logic               last;
  } out_req_t;

  // key event transition, unused codes behave as up
  function automatic key_st_e next_state(key_st_e s, logic press);
    key_st_e r;
    case (s)
      ST_DOWN:     r = press ? ST_REPEAT  : ST_RELEASED;
      ST_PRESSED:  r = press ? ST_DOWN    : ST_RELEASED;
      ST_REPEAT:   r = press ? ST_REPEAT  : ST_RELEASED;
      ST_RELEASED: r = press ? ST_PRESSED : ST_UP;
      default:     r = press ? ST_PRESSED : ST_UP;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/kst_key_mem.sv
module kst_key_mem import kst_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output entry_t   rd_data_o
);

  logic [Depth-1:0] valid_q;
  entry_t           mem_q [Depth];
  entry_t           rd_data_q;

  // per-entry valid bits, an entry never written reads as up / zero / zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr[AddrW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[AddrW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= valid_q[req_i.rd_addr[AddrW-1:0]] ?
                   mem_q[req_i.rd_addr[AddrW-1:0]] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/key_state_autorepeat_tracker.sv
// key state tracker with typematic auto-repeat
//
// input channel (in_valid_i / in_ready_o / in_req_i) takes one request at a
// time: a key event or a time tick. a key event updates one key entry by a
// read and a write back; it never gives a result. an out of range key is
// dropped at once. a tick sweeps all NUM_KEYS entries through the key
// memory, one entry per cycle while the sweep is not paused, with read and
// write back overlapped.
// each repeating key gives one result on the output channel (out_valid_o /
// out_ready_i / out_req_o), in ascending key order; the last one of a tick
// carries last = 1. a result is held until the sweep finds the next repeat
// or ends, so its last flag is known before it is passed on. the sweep
// pauses while a new result finds both the held one and the output register
// full; it resumes as soon as the receiver takes a result. a new request is
// taken while a finished result still waits in the output register.
// reset clears all key entries to up with zero time and character (valid
// bits in the memory, no clearing sweep) and loads the repeat delay and
// interval defaults. configuration writes go through cfg_we_i while the
// block is idle; the user must keep to this, the block does not enforce it.
module key_state_autorepeat_tracker import kst_pkg::*; #(
  parameter int unsigned NUM_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_req_t           out_req_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned AddrW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_KEYS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY_WR,
    S_SCAN,
    S_FLUSH
  } fsm_e;

  fsm_e             state_q;
  logic [CntW-1:0]  issue_cnt_q;
  logic [AddrW-1:0] proc_idx_q;
  logic [ElapW-1:0] elapsed_q;
  logic [KeyW-1:0]  key_q;
  logic             press_q;
  logic [CharW-1:0] char_q;
  logic             pend_vld_q;
  logic [KeyW-1:0]  pend_key_q;
  logic [CharW-1:0] pend_char_q;
  logic             out_vld_q;
  out_req_t         out_q;
  logic [CfgW-1:0]  delay_q;
  logic [CfgW-1:0]  interval_q;

  mem_req_t         mem_req;
  entry_t           rd_data;

  logic             in_acc;
  logic             key_ok;
  logic             more;
  logic             out_free;
  logic             out_load;
  logic             stall;
  logic             fire;
  key_st_e          scan_st;
  logic [TimeW-1:0] scan_time;
  logic [TimeW:0]   time_sum;
  entry_t           scan_wr;
  entry_t           key_wr;

  kst_key_mem #(
    .Depth (NUM_KEYS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // configuration registers, indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DELAY_RESET;
      interval_q <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY:    delay_q    <= cfg_wdata_i;
        CFG_INTERVAL: interval_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign key_ok     = ({1'b0, in_req_i.key_index} < (KeyW + 1)'(NUM_KEYS));
  assign more       = (issue_cnt_q < CntW'(NUM_KEYS));
  assign out_free   = !out_vld_q || out_ready_i;

  // tick update of the entry coming out of the memory
  assign time_sum = {1'b0, rd_data.held} + (TimeW + 1)'(elapsed_q);

  always_comb begin
    scan_st   = ST_UP;
    scan_time = '0;
    case (rd_data.st)
      ST_PRESSED: begin
        scan_st   = ST_DOWN;
        scan_time = '0;
      end
      ST_RELEASED: begin
        scan_st   = ST_UP;
        scan_time = '0;
      end
      ST_DOWN, ST_REPEAT: begin
        scan_st   = rd_data.st;
        scan_time = time_sum[TimeW] ? TIME_MAX : time_sum[TimeW-1:0];
      end
      default: begin
        // up and unused codes keep counting as up
        scan_st   = ST_UP;
        scan_time = time_sum[TimeW] ? TIME_MAX : time_sum[TimeW-1:0];
      end
    endcase
  end

  assign fire = ((scan_st == ST_DOWN) && (scan_time > delay_q)) ||
                ((scan_st == ST_REPEAT) && (scan_time > interval_q));

  // sweep waits only when a new repeat finds nowhere to go
  assign stall = (state_q == S_SCAN) && fire && pend_vld_q && !out_free;

  // a held repeat moves to the output register
  assign out_load = ((state_q == S_SCAN) && fire && pend_vld_q && !stall) ||
                    ((state_q == S_FLUSH) && pend_vld_q && out_free);

  always_comb begin
    scan_wr.st   = fire ? ST_REPEAT : scan_st;
    scan_wr.held = fire ? '0 : scan_time;
    scan_wr.chr  = rd_data.chr;
    key_wr.st    = next_state(rd_data.st, press_q);
    key_wr.held  = rd_data.held;
    key_wr.chr   = char_q;
  end

  // memory request: read next entry while writing back the current one
  always_comb begin
    mem_req = '0;
    case (state_q)
      S_IDLE: begin
        mem_req.rd_en   = in_acc && ((in_req_i.opcode == OP_TICK) || key_ok);
        mem_req.rd_addr = (in_req_i.opcode == OP_TICK) ? '0 : in_req_i.key_index;
      end
      S_KEY_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = key_q;
        mem_req.wr_data = key_wr;
      end
      S_SCAN: begin
        mem_req.rd_en   = !stall && more;
        mem_req.rd_addr = KeyW'(issue_cnt_q[AddrW-1:0]);
        mem_req.wr_en   = !stall;
        mem_req.wr_addr = KeyW'(proc_idx_q);
        mem_req.wr_data = scan_wr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_cnt_q <= '0;
      proc_idx_q  <= '0;
      elapsed_q   <= '0;
      key_q       <= '0;
      press_q     <= 1'b0;
      char_q      <= '0;
      pend_vld_q  <= 1'b0;
      pend_key_q  <= '0;
      pend_char_q <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            elapsed_q <= in_req_i.elapsed_ms;
            key_q     <= in_req_i.key_index;
            press_q   <= in_req_i.is_press;
            char_q    <= in_req_i.key_char;
            if (in_req_i.opcode == OP_TICK) begin
              issue_cnt_q <= CntW'(1);
              proc_idx_q  <= '0;
              state_q     <= S_SCAN;
            end else if (key_ok) begin
              state_q <= S_KEY_WR;
            end
          end
        end
        S_KEY_WR: begin
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (!stall) begin
            if (fire) begin
              // a held repeat is now known not to be the last one
              if (pend_vld_q) begin
                out_q.repeat_key  <= pend_key_q;
                out_q.repeat_char <= pend_char_q;
                out_q.last        <= 1'b0;
              end
              pend_vld_q  <= 1'b1;
              pend_key_q  <= KeyW'(proc_idx_q);
              pend_char_q <= rd_data.chr;
            end
            if (more) begin
              proc_idx_q  <= issue_cnt_q[AddrW-1:0];
              issue_cnt_q <= issue_cnt_q + CntW'(1);
            end else begin
              state_q <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q.repeat_key  <= pend_key_q;
            out_q.repeat_char <= pend_char_q;
            out_q.last        <= 1'b1;
            pend_vld_q        <= 1'b0;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  // no repeat may be left behind once the block takes new requests
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_vld_q)
    else $error("repeat still held while idle");

  // write back and next read never hit the same entry
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
    else $error("memory read and write on the same entry");

  // a paused sweep keeps its place
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (state_q == S_SCAN) && $stable(proc_idx_q) && $stable(issue_cnt_q))
    else $error("sweep moved while paused");

  // a result leaving the sweep always finds the output register free
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && fire && pend_vld_q && !stall) |-> out_free)
    else $error("result overwrote waiting output");

endmodule

>>> bench/tb_key_state_autorepeat_tracker.sv
module tb_key_state_autorepeat_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import kst_pkg::*;

  localparam int NKEYS = 64;
  localparam int NDIR = 26;
  // a tick sweeps every key entry, so allow well over one sweep when settling
  localparam int SETTLE_CYCLES = 150;

  // directed row: one request, and whether it plainly gives no repeat
  typedef struct {
    in_req_t req;
    logic    quiet;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_req_t out_req_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_DELAY;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  // mirror of the key table and timing registers
  key_st_e key_mode [NKEYS];
  logic [TimeW-1:0] key_held [NKEYS];
  logic [CharW-1:0] key_chr [NKEYS];
  logic [CfgW-1:0] delay_ms;
  logic [CfgW-1:0] interval_ms;

  out_req_t new_repeats [$];
  out_req_t repeats_due [$];
  int bad_count = 0;
  logic steady = 1'b0;

  // directed table: every key transition, field extremes, strict thresholds
  dir_row_t dir_rows [NDIR] = '{
    '{'{OP_TICK, 10'd0, 6'd0, 1'b0, 8'h00}, 1'b1},     // tick after reset, all up
    '{'{OP_TICK, 10'd1023, 6'd63, 1'b1, 8'hFF}, 1'b1}, // elapsed past 1000, up keys count
    '{'{OP_KEY, 10'd0, 6'd10, 1'b0, 8'hF0}, 1'b1},     // up, release
    '{'{OP_KEY, 10'd1023, 6'd0, 1'b1, 8'h00}, 1'b1},   // up, press
    '{'{OP_KEY, 10'd0, 6'd63, 1'b1, 8'hFF}, 1'b1},     // top key pressed
    '{'{OP_KEY, 10'd0, 6'd63, 1'b0, 8'h5A}, 1'b1},     // pressed, release
    '{'{OP_KEY, 10'd0, 6'd63, 1'b1, 8'hC3}, 1'b1},     // released, press
    '{'{OP_KEY, 10'd0, 6'd0, 1'b1, 8'h81}, 1'b1},      // pressed, press -> down
    '{'{OP_TICK, 10'd0, 6'd0, 1'b0, 8'h00}, 1'b0},     // down key with old time fires
    '{'{OP_TICK, 10'd1000, 6'd0, 1'b0, 8'h00}, 1'b0},  // two repeats in key order
    '{'{OP_KEY, 10'd0, 6'd0, 1'b1, 8'h11}, 1'b1},      // repeating, press
    '{'{OP_KEY, 10'd0, 6'd63, 1'b0, 8'h22}, 1'b1},     // repeating, release
    '{'{OP_TICK, 10'd50, 6'd0, 1'b0, 8'h00}, 1'b0},
    '{'{OP_TICK, 10'd51, 6'd0, 1'b0, 8'h00}, 1'b0},    // just over the interval
    '{'{OP_TICK, 10'd100, 6'd0, 1'b0, 8'h00}, 1'b0},   // exactly the interval, no fire
    '{'{OP_KEY, 10'd0, 6'd0, 1'b0, 8'h33}, 1'b1},
    '{'{OP_KEY, 10'd0, 6'd0, 1'b0, 8'h44}, 1'b1},      // released, release
    '{'{OP_KEY, 10'd0, 6'd5, 1'b1, 8'h66}, 1'b1},
    '{'{OP_KEY, 10'd0, 6'd5, 1'b0, 8'h55}, 1'b1},
    '{'{OP_KEY, 10'd0, 6'd5, 1'b0, 8'h56}, 1'b1},
    '{'{OP_KEY, 10'd0, 6'd7, 1'b1, 8'h77}, 1'b1},
    '{'{OP_KEY, 10'd0, 6'd9, 1'b1, 8'h99}, 1'b1},
    '{'{OP_TICK, 10'd500, 6'd0, 1'b0, 8'h00}, 1'b0},   // pressed settles, time cleared
    '{'{OP_KEY, 10'd0, 6'd7, 1'b1, 8'h78}, 1'b1},      // down, press
    '{'{OP_KEY, 10'd0, 6'd9, 1'b0, 8'h9A}, 1'b1},      // down, release
    '{'{OP_TICK, 10'd101, 6'd0, 1'b0, 8'h00}, 1'b0}
  };

  key_state_autorepeat_tracker #(
    .NUM_KEYS(NKEYS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // key table mirror: key events walk the transition table, ticks settle,
  // age and fire every key in ascending order
  function automatic void sweep_keys(in_req_t r);
    key_st_e s;
    logic [TimeW:0] t;
    logic fire;
    out_req_t rep;
    new_repeats.delete();
    if (r.opcode == OP_KEY) begin
      // with 64 keys every index is in range
      if (int'(r.key_index) < NKEYS) begin
        case (key_mode[r.key_index])
          ST_DOWN, ST_REPEAT: s = r.is_press ? ST_REPEAT : ST_RELEASED;
          ST_PRESSED:         s = r.is_press ? ST_DOWN : ST_RELEASED;
          default:            s = r.is_press ? ST_PRESSED : ST_UP;
        endcase
        key_mode[r.key_index] = s;
        key_chr[r.key_index] = r.key_char;
      end
      return;
    end
    for (int i = 0; i < NKEYS; i++) begin
      s = key_mode[i];
      if (s == ST_PRESSED) begin
        s = ST_DOWN;
        t = '0;
      end else if (s == ST_RELEASED) begin
        s = ST_UP;
        t = '0;
      end else begin
        if (s != ST_DOWN && s != ST_REPEAT) s = ST_UP;
        // up keys keep counting too; time sticks at the top
        t = {1'b0, key_held[i]} + (TimeW+1)'(r.elapsed_ms);
        if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
      end
      fire = (s == ST_DOWN && t > {1'b0, delay_ms}) ||
             (s == ST_REPEAT && t > {1'b0, interval_ms});
      if (fire) begin
        s = ST_REPEAT;
        t = '0;
        rep.repeat_key = KeyW'(i);
        rep.repeat_char = key_chr[i];
        rep.last = 1'b0;
        new_repeats.push_back(rep);
      end
      key_mode[i] = s;
      key_held[i] = t[TimeW-1:0];
    end
    if (new_repeats.size() != 0) begin
      rep = new_repeats.pop_back();
      rep.last = 1'b1;
      new_repeats.push_back(rep);
    end
  endfunction

  // random request: mostly a handful of hot keys so press, hold and release
  // sequences build up on the same entries
  function automatic in_req_t random_req();
    in_req_t r;
    int pick;
    r.opcode = $urandom_range(0, 1) ? OP_KEY : OP_TICK;
    pick = $urandom_range(0, 99);
    if (pick < 10) r.elapsed_ms = '0;
    else if (pick < 20) r.elapsed_ms = ElapW'($urandom_range(1001, 1023));
    else r.elapsed_ms = ElapW'($urandom_range(0, 1000));
    if ($urandom_range(0, 99) < 70) r.key_index = KeyW'($urandom_range(0, 7) * 9);
    else r.key_index = KeyW'($urandom_range(0, 63));
    r.is_press = ($urandom_range(0, 99) < 60);
    r.key_char = CharW'($urandom);
    return r;
  endfunction

  // enters and leaves on a falling edge; valid stays high until taken
  task automatic push_req(input in_req_t r, input logic quiet);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sweep_keys(r);
    // a quiet row plainly gives nothing, so the table stands as the expectation
    if (!quiet) foreach (new_repeats[k]) repeats_due.push_back(new_repeats[k]);
    @(negedge clk_i);
  endtask

  // wait for every repeat, then let a sweep with no repeat run out
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (repeats_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // both registers back to back, only while the block is idle
  task automatic set_timing(input logic [CfgW-1:0] dly, input logic [CfgW-1:0] ivl);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DELAY;
    cfg_wdata_i <= dly;
    @(negedge clk_i);
    cfg_idx_i <= CFG_INTERVAL;
    cfg_wdata_i <= ivl;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    delay_ms = dly;
    interval_ms = ivl;
  endtask

  // receiver stalls at random except in the steady stretch
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 25);
  end

  // repeat checker: each taken result against the oldest expectation
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (repeats_due.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected repeat: key %0d char %h last %b", out_req_o.repeat_key,
                   out_req_o.repeat_char, out_req_o.last);
        bad_count++;
      end else begin
        want = repeats_due.pop_front();
        if (out_req_o.repeat_key !== want.repeat_key ||
            out_req_o.repeat_char !== want.repeat_char ||
            out_req_o.last !== want.last) begin
          if (bad_count < 10)
            $display("repeat mismatch: exp key %0d char %h last %b, got key %0d char %h last %b",
                     want.repeat_key, want.repeat_char, want.last, out_req_o.repeat_key,
                     out_req_o.repeat_char, out_req_o.last);
          bad_count++;
        end
      end
    end
  end

  initial begin
    int n_rand;
    for (int i = 0; i < NKEYS; i++) begin
      key_mode[i] = ST_UP;
      key_held[i] = '0;
      key_chr[i] = '0;
    end
    delay_ms = DELAY_RESET;
    interval_ms = INTERVAL_RESET;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part on the reset timing
    foreach (dir_rows[k]) push_req(dir_rows[k].req, dir_rows[k].quiet);

    // random part: timing phases change every 60 requests, with a stretch of
    // requests 100 to 159 where neither side idles
    n_rand = 0;
    while (n_rand < 204) begin
      if (n_rand % 60 == 0) begin
        drain_block();
        case ((n_rand / 60) % 4)
          1: set_timing('0, '0);
          2: set_timing({CfgW{1'b1}}, {CfgW{1'b1}});
          3: set_timing(CfgW'($urandom_range(200, 2000)), CfgW'($urandom_range(0, 500)));
          default: set_timing(DELAY_RESET, INTERVAL_RESET);
        endcase
      end
      steady = (n_rand >= 100 && n_rand < 160);
      push_req(random_req(), 1'b0);
      n_rand++;
    end
    steady = 1'b0;
    drain_block();

    if (bad_count == 0) begin
      $display("tb_key_state_autorepeat_tracker passed");
    end else begin
      $display("tb_key_state_autorepeat_tracker failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("tb_key_state_autorepeat_tracker failed");
    $finish;
  end

endmodule
